>>> design/esest_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the encoder speed estimator.
// No dependencies; imported by the controller, datapath and top level.
package esest_pkg;

    localparam int POS_W    = 13;
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 29;
    localparam int DELTA_W  = 14;
    localparam int WEIGHT_W = 17;
    localparam int QUO_W    = 30;  // |delta| << 16
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 47;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = 5;

    localparam int DELTA_MAX = 8191;
    localparam int DELTA_MIN = -8192;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd1966;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 29'sh0FFF_FFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 29'sh1000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;      // take the input transfer, load divider
        logic div_step;  // one restoring divide step
        logic mul;       // clamp quotient, multiply error by weight
        logic acc;       // update smoothed speed
        logic ld_out;    // load the output register
    } cmd_t;

    typedef struct packed {
        logic elapsed_zero;  // incoming sample has zero elapsed time
        logic out_free;      // output register empty or being drained
    } sts_t;

endpackage

>>> design/encoder_speed_estimator.sv
`timescale 1ns / 1ps
// Encoder speed estimator, top level. Instantiates esest_ctrl and
// esest_datapath; types and constants from esest_pkg.
//
// Takes one encoder sample per transfer (position within a turn plus a
// free-running microsecond timestamp), unwraps the position change into
// plus or minus half a turn, divides it by the elapsed time to get a raw
// speed in counts per microsecond (signed Q12.16, truncated toward zero,
// saturated), and smooths it with an exponential average weighted by
// smoothing_weight (Q1.16, values above 1.0 act as 1.0). A sample with
// zero elapsed time skips the divide, holds the average and sets the
// time_zero flag in m_tuser. One sample is processed at a time: a normal
// sample goes from its transfer through the 30-step restoring divider
// (one quotient bit per cycle), multiply, accumulate and output load,
// which waits for a free output register; a zero-interval sample goes
// from accept straight to output load. Results sit in an output
// register, so the next sample is taken while a result waits on m_tready.
// smoothing_weight resets to 1966 (about 0.03) and is written by cfg_we.
module encoder_speed_estimator
    import esest_pkg::*;
#(
    parameter int COUNTS_PER_TURN = 8192  // 4 .. 2^24
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // smoothing weight, Q1.16
    input  logic                   cfg_we,
    input  logic [WEIGHT_W-1:0]    cfg_wdata,

    // sample input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [12:0] position, [44:13] sample_time

    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [28:0] speed_filtered, [42:29] position_delta
    output logic                   m_tuser    // [0] time_zero
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: idle -> divide -> multiply -> accumulate -> output, or idle -> output for a zero interval
    esest_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, filter state and output register
    esest_datapath #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> design/esest_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the speed estimator: one sample at a time through divide,
// multiply and accumulate. Depends on esest_pkg.
module esest_ctrl
    import esest_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = sts.elapsed_zero ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // divide step counter never runs past the last quotient bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg <= CNT_W'(DIV_STEPS - 1))
        else $error("esest_ctrl: divide counter overrun");

    // zero elapsed time bypasses the divider and filter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && sts.elapsed_zero) |=> state_reg == ST_OUT)
        else $error("esest_ctrl: zero-interval sample entered the divider");

    // multiply always follows a divide step
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> $past(cmd.div_step))
        else $error("esest_ctrl: multiply without completed divide");

    // never overwrite an undelivered result
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> sts.out_free)
        else $error("esest_ctrl: output overwritten");

endmodule

>>> design/esest_datapath.sv
`timescale 1ns / 1ps
// Datapath: unwrap, restoring divider, weighted error multiply, average
// update and output register. Depends on esest_pkg; driven by esest_ctrl.
module esest_datapath
    import esest_pkg::*;
#(
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [WEIGHT_W-1:0]    cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    // unwrap width covers a position difference plus or minus one turn
    localparam int TURN_BITS = $clog2(COUNTS_PER_TURN);
    localparam int UW = ((TURN_BITS > POS_W) ? TURN_BITS : POS_W) + 2;
    localparam logic signed [UW-1:0] TURN_S = UW'(COUNTS_PER_TURN);
    localparam logic signed [UW-1:0] HALF_S = UW'(COUNTS_PER_TURN / 2);
    localparam logic signed [UW-1:0] DMAX_S = UW'(DELTA_MAX);
    localparam logic signed [UW-1:0] DMIN_S = UW'(DELTA_MIN);

    logic [WEIGHT_W-1:0]       weight_reg;
    logic [POS_W-1:0]          prev_pos_reg;
    logic [TIME_W-1:0]         prev_time_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic                      zero_reg;
    logic [TIME_W-1:0]         divisor_reg;
    logic [TIME_W-1:0]         rem_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;
    logic                      m_tuser_reg;

    // input unpack
    logic [POS_W-1:0]  in_pos;
    logic [TIME_W-1:0] in_time;
    logic [TIME_W-1:0] elapsed;
    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_time = s_tdata[POS_W +: TIME_W];
    assign elapsed = in_time - prev_time_reg;

    // unwrap into half a turn, then saturate to the delta range
    logic signed [UW-1:0]      d_raw, d_unw;
    logic signed [DELTA_W-1:0] d_sat;
    logic [DELTA_W-1:0]        d_abs;
    always_comb begin
        d_raw = $signed(UW'(in_pos)) - $signed(UW'(prev_pos_reg));
        if (d_raw > HALF_S) begin
            d_unw = d_raw - TURN_S;
        end else if (d_raw < -HALF_S) begin
            d_unw = d_raw + TURN_S;
        end else begin
            d_unw = d_raw;
        end
        if (d_unw > DMAX_S) begin
            d_sat = DELTA_W'(DELTA_MAX);
        end else if (d_unw < DMIN_S) begin
            d_sat = DELTA_W'(DELTA_MIN);
        end else begin
            d_sat = d_unw[DELTA_W-1:0];
        end
        d_abs = d_sat[DELTA_W-1] ? DELTA_W'(-d_sat) : DELTA_W'(d_sat);
    end

    // restoring divide step
    logic [TIME_W:0] trial;
    assign trial = {rem_reg, quo_reg[QUO_W-1]} - {1'b0, divisor_reg};

    // quotient to signed raw speed, saturated
    logic                      q_pos_ovf, q_neg_ovf;
    logic signed [SPEED_W-1:0] raw;
    logic signed [SPEED_W:0]   err;
    logic [WEIGHT_W-1:0]       w_sat;
    logic signed [PROD_W-1:0]  prod_full;
    always_comb begin
        q_pos_ovf = quo_reg > QUO_W'(SPEED_MAX);
        q_neg_ovf = quo_reg > QUO_W'(SPEED_MAX) + 1'b1;
        if (delta_reg[DELTA_W-1]) begin
            raw = q_neg_ovf ? SPEED_MIN : -$signed(quo_reg[SPEED_W-1:0]);
        end else begin
            raw = q_pos_ovf ? SPEED_MAX : $signed(quo_reg[SPEED_W-1:0]);
        end
        err       = $signed({raw[SPEED_W-1], raw}) - $signed({speed_reg[SPEED_W-1], speed_reg});
        w_sat     = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
        prod_full = err * $signed({1'b0, w_sat});
    end

    // round to nearest (ties up), add, saturate
    logic signed [PROD_W-1:0]        prod_rnd;
    logic signed [PROD_W-FRAC_W-1:0] step;
    logic signed [SPEED_W+2:0]       sum;
    logic signed [SPEED_W-1:0]       speed_new;
    always_comb begin
        prod_rnd = prod_reg + PROD_W'(32768);
        step     = prod_rnd[PROD_W-1:FRAC_W];
        sum      = $signed({{3{speed_reg[SPEED_W-1]}}, speed_reg})
                 + $signed({step[PROD_W-FRAC_W-1], step});
        if (sum > $signed((SPEED_W+3)'(SPEED_MAX))) begin
            speed_new = SPEED_MAX;
        end else if (sum < $signed({{3{1'b1}}, SPEED_MIN})) begin
            speed_new = SPEED_MIN;
        end else begin
            speed_new = sum[SPEED_W-1:0];
        end
    end

    // state with reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg    <= WEIGHT_RESET;
            prev_pos_reg  <= '0;
            prev_time_reg <= '0;
            speed_reg     <= '0;
        end else begin
            if (cfg_we) begin
                weight_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                prev_pos_reg  <= in_pos;
                prev_time_reg <= in_time;
            end
            if (cmd.acc) begin
                speed_reg <= speed_new;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            delta_reg   <= d_sat;
            zero_reg    <= (elapsed == '0);
            divisor_reg <= elapsed;
            rem_reg     <= '0;
            quo_reg     <= {d_abs, {FRAC_W{1'b0}}};
        end else if (cmd.div_step) begin
            if (!trial[TIME_W]) begin
                rem_reg <= trial[TIME_W-1:0];
            end else begin
                rem_reg <= {rem_reg[TIME_W-2:0], quo_reg[QUO_W-1]};
            end
            quo_reg <= {quo_reg[QUO_W-2:0], ~trial[TIME_W]};
        end
        if (cmd.mul) begin
            prod_reg <= prod_full;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.ld_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_tdata_reg <= {{(OUT_TDATA_W-SPEED_W-DELTA_W){1'b0}}, delta_reg, speed_reg};
            m_tuser_reg <= zero_reg;
        end
    end

    assign sts.elapsed_zero = (elapsed == '0);
    assign sts.out_free     = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> tb/esest_speed_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the encoder speed estimator: predicts each result from the
// accepted samples and weight writes, then checks the result channel.
// Depends on esest_pkg.
module esest_speed_checker
    import esest_pkg::*;
#(
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [WEIGHT_W-1:0]    cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [12:0] position, [44:13] sample_time
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,    // [28:0] speed_filtered, [42:29] position_delta
    input  logic                   m_tuser,    // [0] time_zero
    output int                     error_count,
    output int                     pending_count,
    output int                     checked_count,
    output int                     zero_count
);

    localparam longint SPEED_HI = longint'(SPEED_MAX);
    localparam longint SPEED_LO = longint'(SPEED_MIN);
    localparam int     MAX_REPORTS = 40;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [DELTA_W-1:0] delta;
        logic                      time_zero;
    } speed_result_t;

    // predictor state
    logic [WEIGHT_W-1:0] weight_q;
    logic [POS_W-1:0]    last_pos;
    logic [TIME_W-1:0]   last_stamp;
    longint              avg_speed;

    speed_result_t expected_speed_q[$];
    speed_result_t want;
    int            errs;
    int            checked;
    int            zeros;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // one sample through the estimator; updates the predictor state
    function automatic speed_result_t predict_speed(input logic [POS_W-1:0] pos,
                                                    input logic [TIME_W-1:0] stamp);
        int                diff;
        logic [TIME_W-1:0] elapsed;
        longint            quo;
        longint            raw;
        longint            wt;
        longint            prod;
        speed_result_t     r;
        diff = int'(pos) - int'(last_pos);
        if (diff > COUNTS_PER_TURN / 2)
            diff -= COUNTS_PER_TURN;
        else if (diff < -(COUNTS_PER_TURN / 2))
            diff += COUNTS_PER_TURN;
        diff = int'(clip(diff, DELTA_MIN, DELTA_MAX));
        elapsed = stamp - last_stamp;
        r.time_zero = (elapsed == '0);
        if (!r.time_zero) begin
            quo  = (longint'(diff < 0 ? -diff : diff) << FRAC_W) / longint'(elapsed);
            raw  = clip(diff < 0 ? -quo : quo, SPEED_LO, SPEED_HI);
            wt   = (weight_q > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_q);
            prod = (raw - avg_speed) * wt;
            // round to nearest, ties up: floor((p + 2^15) / 2^16)
            avg_speed = clip(avg_speed + ((prod + 32768) >>> FRAC_W), SPEED_LO, SPEED_HI);
        end
        last_pos   = pos;
        last_stamp = stamp;
        r.speed = avg_speed[SPEED_W-1:0];
        r.delta = diff[DELTA_W-1:0];
        return r;
    endfunction

    task automatic report_field(input string field, input longint exp_v, input longint got_v);
        errs++;
        if (errs <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            weight_q   = WEIGHT_RESET;
            last_pos   = '0;
            last_stamp = '0;
            avg_speed  = 0;
            expected_speed_q.delete();
        end else begin
            if (cfg_we)
                weight_q = cfg_wdata;

            // a result leaves in a later cycle than its sample, so check first
            if (m_tvalid && m_tready) begin
                if (expected_speed_q.size() == 0) begin
                    errs++;
                    if (errs <= MAX_REPORTS)
                        $error("result transfer with no sample pending (speed_filtered %0d)",
                               $signed(m_tdata[28:0]));
                end else begin
                    want = expected_speed_q.pop_front();
                    checked++;
                    if ($signed(m_tdata[28:0]) != want.speed)
                        report_field("speed_filtered", want.speed, $signed(m_tdata[28:0]));
                    if ($signed(m_tdata[42:29]) != want.delta)
                        report_field("position_delta", want.delta, $signed(m_tdata[42:29]));
                    if (m_tuser !== want.time_zero)
                        report_field("time_zero", want.time_zero, m_tuser);
                    if (m_tdata[OUT_TDATA_W-1:43] !== '0)
                        report_field("tdata padding", 0, m_tdata[OUT_TDATA_W-1:43]);
                end
            end

            if (s_tvalid && s_tready) begin
                want = predict_speed(s_tdata[12:0], s_tdata[44:13]);
                if (want.time_zero)
                    zeros++;
                expected_speed_q.push_back(want);
            end
        end
        error_count   <= errs;
        pending_count <= expected_speed_q.size();
        checked_count <= checked;
        zero_count    <= zeros;
    end

endmodule

>>> tb/tb_encoder_speed_estimator.sv
`timescale 1ns / 1ps
// Top of the encoder speed estimator testbench: clock, reset, sample and
// weight stimulus, result-side back-pressure and the verdict.
// Depends on esest_pkg, encoder_speed_estimator and esest_speed_checker.
module tb_encoder_speed_estimator
    import esest_pkg::*;
();

    localparam int TURN         = 8192;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 78;          // ~700 random samples in all
    // The limit leaves several times the slowest run of ~720 samples with
    // the longest gaps and stalls.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 40;          // idle tail after the last phase

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [WEIGHT_W-1:0]    cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;     // [12:0] position, [44:13] sample_time
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // [28:0] speed_filtered, [42:29] position_delta
    logic                   m_tuser;     // [0] time_zero

    int error_count;
    int pending_results;
    int checked_count;
    int zero_count;

    // sender-side copy of the last accepted sample, used to build steps
    int                last_pos;
    logic [TIME_W-1:0] last_stamp;
    int                sent_count;
    int                weight_writes;

    encoder_speed_estimator #(
        .COUNTS_PER_TURN (TURN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    esest_speed_checker #(
        .COUNTS_PER_TURN (TURN)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_results),
        .checked_count (checked_count),
        .zero_count    (zero_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_encoder_speed_estimator: done, errors");
        $finish;
    end

    // Mostly short gaps between transfers, now and then a long one.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // Present one sample and hold it until the transfer. With gap > 0 the
    // valid drops for the gap (tdata carries junk meanwhile);
    // with gap == 0 the next call keeps valid high for back-to-back.
    task automatic send_sample(input logic [POS_W-1:0] pos, input logic [TIME_W-1:0] stamp,
                               input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - POS_W - TIME_W){1'b0}}, stamp, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        last_pos   = pos;
        last_stamp = stamp;
        sent_count++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_TDATA_W'({$urandom(), $urandom()});
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Relative step from the last sample; position wraps modulo one turn.
    task automatic send_step(input int dpos, input logic [TIME_W-1:0] dt, input int gap);
        send_sample(POS_W'(last_pos + dpos), last_stamp + dt, gap);
    endtask

    // Hold the sender until every predicted result has left the block.
    // The first edge lets the checker's count catch the last transfer.
    // Every sample yields a result, so an empty scoreboard means idle; the
    // few extra cycles are margin only.
    task automatic wait_results_drained();
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        cfg_wdata <= w;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        weight_writes++;
        @(posedge aclk);
    endtask

    // One random sample. Half are steady motion at the phase's speed; the
    // rest hit tiny intervals, zero intervals, huge or wrapped intervals,
    // steps around half a turn, or are unrelated noise.
    task automatic send_random_sample(input int vel, input int gap);
        int                kind;
        int                dt_small;
        int                dpos;
        logic [TIME_W-1:0] dt;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            dt_small = $urandom_range(20, 80);
            dpos     = (vel * dt_small) / 64 + int'($urandom_range(0, 4)) - 2;
            send_step(dpos, TIME_W'(dt_small), gap);
        end else if (kind < 60) begin
            send_step(int'($urandom_range(0, 8192)) - 4096,
                      TIME_W'($urandom_range(1, 3)), gap);
        end else if (kind < 68) begin
            // zero elapsed time: average held, flag raised
            send_step(int'($urandom_range(0, 8191)) - 4096, '0, gap);
        end else if (kind < 78) begin
            dt = $urandom();
            send_step(int'($urandom_range(0, 8191)) - 4096, dt, gap);
        end else if (kind < 88) begin
            case ($urandom_range(0, 7))
                0:       dpos = 4095;
                1:       dpos = 4096;
                2:       dpos = 4097;
                3:       dpos = -4095;
                4:       dpos = -4096;
                5:       dpos = -4097;
                6:       dpos = 8191;
                default: dpos = -8191;
            endcase
            send_step(dpos, TIME_W'($urandom_range(1, 4)), gap);
        end else begin
            send_sample(POS_W'($urandom()), $urandom(), gap);
        end
    endtask

    // Result side: ready in runs, mostly short stalls, a few long ones,
    // and now and then a long stretch with no stall at all.
    initial begin
        int on_len;
        int off_len;
        int r;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 250)
                                                 : $urandom_range(1, 10);
            m_tready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            r = $urandom_range(0, 99);
            if (r < 35)      off_len = 0;
            else if (r < 85) off_len = $urandom_range(1, 4);
            else if (r < 96) off_len = $urandom_range(5, 25);
            else             off_len = $urandom_range(40, 150);
            if (off_len > 0) begin
                m_tready <= 1'b0;
                repeat (off_len) @(posedge aclk);
            end
        end
    end

    // Main stimulus
    initial begin
        int                  ph;
        int                  i;
        int                  gap;
        int                  vel;
        logic [WEIGHT_W-1:0] w;

        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        aresetn       <= 1'b0;
        last_pos      = 0;
        last_stamp    = '0;
        sent_count    = 0;
        weight_writes = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed, reset weight (about 0.03) ----
        // first sample after reset sees position 0 at time 0: zero interval
        send_sample(13'd0,    32'd0, rand_gap());
        // +half a turn over 1 us: raw speed clips at the top of Q12.16
        send_sample(13'd4096, 32'd1, rand_gap());
        // -half a turn: raw speed lands exactly on the bottom of the range
        send_sample(13'd0,    32'd2, rand_gap());
        // just over half a turn either way unwraps to the other side
        send_sample(13'd4097, 32'd3, rand_gap());
        send_sample(13'd0,    32'd4, rand_gap());
        // crossing the index in both directions
        send_sample(13'd8191, 32'd5, rand_gap());
        send_sample(13'd0,    32'd6, rand_gap());
        // repeated sample: zero interval, zero delta
        send_sample(13'd0,    32'd6, rand_gap());
        // huge interval, then a timer that wraps past 2^32
        send_sample(13'd100,  32'hFFFF_FFFF, rand_gap());
        send_sample(13'd8191, 32'd3, rand_gap());
        // zero interval with a nonzero position change
        send_sample(13'd0,    32'd3, 1);
        wait_results_drained();

        // ---- weight 1.0: average follows raw speed, full swing ----
        write_weight(WEIGHT_ONE);
        send_sample(13'd4096, 32'd4, rand_gap());
        send_sample(13'd0,    32'd5, rand_gap());
        send_sample(13'd4096, 32'd6, 1);
        wait_results_drained();

        // ---- weight field all ones: saturates to 1.0 ----
        write_weight('1);
        send_sample(13'd0,    32'd7, rand_gap());
        send_sample(13'd4096, 32'd8, 1);
        wait_results_drained();

        // ---- weight 0: average never moves ----
        write_weight('0);
        send_sample(13'd0,    32'd9,  rand_gap());
        send_sample(13'd1,    32'd10, 1);
        wait_results_drained();

        // ---- just above 1.0 ----
        write_weight(WEIGHT_ONE + 17'd1);
        send_sample(13'd4096, 32'd11, rand_gap());
        send_sample(13'd1234, 32'd80, 1);
        wait_results_drained();

        // ---- random phases, one weight each ----
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       w = 17'd1;
                1:       w = 17'd65535;
                2:       w = 17'd32768;
                3:       w = WEIGHT_W'($urandom_range(0, 131071));
                4:       w = WEIGHT_RESET;
                5:       w = WEIGHT_ONE;
                6:       w = '0;
                7:       w = '1;
                default: w = WEIGHT_W'($urandom_range(0, 65536));
            endcase
            write_weight(w);
            // slow or fast rotation, counts per 64 us
            vel = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 256)) - 128
                                              : int'($urandom_range(0, 4000)) - 2000;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                gap = rand_gap();
                if (i == PHASE_ITEMS - 1 || (ph == 2 && i == PHASE_ITEMS / 2))
                    gap = (gap == 0) ? 1 : gap;
                send_random_sample(vel, gap);
                // sender backs off mid-phase until the pipe is empty
                if (ph == 2 && i == PHASE_ITEMS / 2)
                    wait_results_drained();
            end
            wait_results_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d samples sent, %0d results checked, %0d with zero interval",
                 sent_count, checked_count, zero_count);
        $display("summary: %0d weight writes incl. 0, 1, 1.0, above 1.0 and all ones",
                 weight_writes);
        if (error_count == 0 && pending_results == 0)
            $display("tb_encoder_speed_estimator: done, clean");
        else
            $display("tb_encoder_speed_estimator: done, errors");
        $finish;
    end

endmodule
